### rtl/positional_linked_list_engine_unit_assert.svh
// Assertion macros for the linked list engine checker.
// Both sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef POSITIONAL_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PLL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("linked list engine check failed");

// Next-cycle implication.
`define PLL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("linked list engine check failed");

`endif

### rtl/pll_pkg.sv
package pll_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned ST_W    = 3;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    localparam t_op OP_APPEND    = 3'd0;
    localparam t_op OP_PREPEND   = 3'd1;
    localparam t_op OP_INSERT    = 3'd2;
    localparam t_op OP_DEL_FIRST = 3'd3;
    localparam t_op OP_DEL_AT    = 3'd4;
    localparam t_op OP_SEARCH    = 3'd5;

    localparam t_status ST_DONE      = 3'd0;
    localparam t_status ST_FOUND     = 3'd1;
    localparam t_status ST_NOT_FOUND = 3'd2;
    localparam t_status ST_EMPTY     = 3'd3;
    localparam t_status ST_RANGE     = 3'd4;
    localparam t_status ST_FULL      = 3'd5;

    // Strobes from the sequencer to the node store.
    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic value_we;
    } t_mem_ctl;

endpackage

### rtl/pll_ram.sv
module pll_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_re,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pll_ctrl.sv
module pll_ctrl #(
    parameter int unsigned CAPACITY = pll_pkg::CAPACITY_DEF,
    localparam int unsigned LW = $clog2(CAPACITY + 1),
    localparam int unsigned AW = $clog2(CAPACITY)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pll_pkg::t_op                         i_operation,
    input  logic [pll_pkg::POS_W-1:0]            i_position,
    input  logic signed [pll_pkg::VALUE_W-1:0]   i_item_value,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output pll_pkg::t_status                     o_res_status,
    output logic [LW-1:0]                        o_res_length,
    output pll_pkg::t_mem_ctl                    o_mem,
    output logic [AW-1:0]                        o_rd_addr,
    output logic [AW-1:0]                        o_wr_addr,
    output logic [LW-1:0]                        o_link_wdata,
    output logic [pll_pkg::VALUE_W-1:0]          o_value_wdata,
    input  logic [LW-1:0]                        i_link_rdata,
    input  logic [pll_pkg::VALUE_W-1:0]          i_value_rdata
);

    import pll_pkg::*;

    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
    localparam int unsigned   CMPW      = ((LW > POS_W) ? LW : POS_W) + 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_ALLOC  = 10'b00_0000_0010,
        S_POP    = 10'b00_0000_0100,
        S_START  = 10'b00_0000_1000,
        S_WALK   = 10'b00_0001_0000,
        S_LINK   = 10'b00_0010_0000,
        S_UNLINK = 10'b00_0100_0000,
        S_WR     = 10'b00_1000_0000,
        S_SRCH   = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [LW-1:0]        r_head, n_head;
    logic [LW-1:0]        r_free_head, n_free_head;
    logic [LW-1:0]        r_fresh, n_fresh;
    logic [LW-1:0]        r_count, n_count;
    logic [LW-1:0]        r_node, n_node;
    logic [LW-1:0]        r_cur, n_cur;
    logic [LW-1:0]        r_k, n_k;
    logic                 r_pend, n_pend;
    logic                 r_ins, n_ins;
    logic                 r_at_head, n_at_head;
    logic [VALUE_W-1:0]   r_key, n_key;
    t_status              r_status, n_status;

    logic [CMPW-1:0]      pos_x;
    logic [CMPW-1:0]      cnt_x;
    logic [LW-1:0]        cur;

    assign pos_x = CMPW'(i_position);
    assign cnt_x = CMPW'(r_count);
    // Current node of a walk: fresh read data once a hop is in flight.
    assign cur   = r_pend ? i_link_rdata : r_cur;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_RESP);
    assign o_res_status = r_status;
    assign o_res_length = r_count;

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_free_head   = r_free_head;
        n_fresh       = r_fresh;
        n_count       = r_count;
        n_node        = r_node;
        n_cur         = r_cur;
        n_k           = r_k;
        n_pend        = r_pend;
        n_ins         = r_ins;
        n_at_head     = r_at_head;
        n_key         = r_key;
        n_status      = r_status;
        o_mem         = '0;
        o_rd_addr     = cur[AW-1:0];
        o_wr_addr     = r_node[AW-1:0];
        o_link_wdata  = r_head;
        o_value_wdata = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = i_item_value;
                    n_pend   = 1'b0;
                    n_cur    = r_head;
                    n_status = ST_DONE;
                    unique case (i_operation)
                        OP_APPEND: begin
                            n_ins     = 1'b1;
                            n_at_head = (r_count == '0);
                            n_k       = r_count - LW'(1);
                            n_state   = S_ALLOC;
                            if (r_count == NULL_LINK) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end
                        end
                        OP_PREPEND: begin
                            n_ins     = 1'b1;
                            n_at_head = 1'b1;
                            n_state   = S_ALLOC;
                            if (r_count == NULL_LINK) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end
                        end
                        OP_INSERT: begin
                            n_ins     = 1'b1;
                            n_at_head = (pos_x == CMPW'(1));
                            n_k       = LW'(pos_x - CMPW'(2));
                            n_state   = S_ALLOC;
                            if (r_count == NULL_LINK) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                                n_status = ST_RANGE;
                                n_state  = S_RESP;
                            end
                        end
                        OP_DEL_FIRST: begin
                            n_ins     = 1'b0;
                            n_at_head = 1'b1;
                            n_state   = S_START;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end
                        end
                        OP_DEL_AT: begin
                            n_ins     = 1'b0;
                            n_at_head = (pos_x == CMPW'(1));
                            n_k       = LW'(pos_x - CMPW'(2));
                            n_state   = S_START;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                                n_state  = S_RESP;
                            end
                        end
                        OP_SEARCH: begin
                            n_k     = r_count;
                            n_state = S_SRCH;
                        end
                        default: begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (r_fresh != NULL_LINK) begin
                    n_node  = r_fresh;
                    n_fresh = r_fresh + LW'(1);
                    n_state = S_START;
                end else begin
                    // pop the recycled list: its link names the next free node
                    o_mem.rd_en = 1'b1;
                    o_rd_addr   = r_free_head[AW-1:0];
                    n_node      = r_free_head;
                    n_state     = S_POP;
                end
            end
            S_POP: begin
                n_free_head = i_link_rdata;
                n_state     = S_START;
            end
            S_START: begin
                n_cur  = r_head;
                n_pend = 1'b0;
                if (r_at_head && r_ins) begin
                    o_mem.link_we  = 1'b1;
                    o_mem.value_we = 1'b1;
                    n_head         = r_node;
                    n_count        = r_count + LW'(1);
                    n_status       = ST_DONE;
                    n_state        = S_RESP;
                end else if (r_at_head) begin
                    o_mem.rd_en = 1'b1;
                    o_rd_addr   = r_head[AW-1:0];
                    n_state     = S_LINK;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_mem.rd_en = 1'b1;
                n_cur       = cur;
                n_pend      = 1'b1;
                if (r_k == '0) begin
                    n_state = S_LINK;
                end else begin
                    n_k = r_k - LW'(1);
                end
            end
            S_LINK: begin
                if (r_ins) begin
                    o_mem.link_we  = 1'b1;
                    o_mem.value_we = 1'b1;
                    o_link_wdata   = i_link_rdata;
                    n_state        = S_WR;
                end else if (r_at_head) begin
                    o_mem.link_we = 1'b1;
                    o_wr_addr     = r_head[AW-1:0];
                    o_link_wdata  = r_free_head;
                    n_free_head   = r_head;
                    n_head        = i_link_rdata;
                    n_count       = r_count - LW'(1);
                    n_status      = ST_DONE;
                    n_state       = S_RESP;
                end else begin
                    o_mem.rd_en = 1'b1;
                    o_rd_addr   = i_link_rdata[AW-1:0];
                    n_node      = i_link_rdata;
                    n_state     = S_UNLINK;
                end
            end
            S_UNLINK: begin
                o_mem.link_we = 1'b1;
                o_wr_addr     = r_cur[AW-1:0];
                o_link_wdata  = i_link_rdata;
                n_state       = S_WR;
            end
            S_WR: begin
                o_mem.link_we = 1'b1;
                if (r_ins) begin
                    o_wr_addr    = r_cur[AW-1:0];
                    o_link_wdata = r_node;
                    n_count      = r_count + LW'(1);
                end else begin
                    o_link_wdata = r_free_head;
                    n_free_head  = r_node;
                    n_count      = r_count - LW'(1);
                end
                n_status = ST_DONE;
                n_state  = S_RESP;
            end
            S_SRCH: begin
                if (r_pend && i_value_rdata == r_key) begin
                    n_status = ST_FOUND;
                    n_state  = S_RESP;
                end else if (r_k == '0) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_mem.rd_en = 1'b1;
                    n_cur       = cur;
                    n_pend      = 1'b1;
                    n_k         = r_k - LW'(1);
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NULL_LINK;
            r_free_head <= NULL_LINK;
            r_fresh     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_ins       <= 1'b0;
            r_at_head   <= 1'b0;
            r_status    <= ST_DONE;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_ins       <= n_ins;
            r_at_head   <= n_at_head;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_cur  <= n_cur;
        r_k    <= n_k;
        r_key  <= n_key;
    end

endmodule

### rtl/positional_linked_list_engine_unit.sv
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_operation, i_position, i_item_value
// result    out        o_out_valid / i_out_ready  o_status, o_list_length
//
// One request at a time. A request checked as full, empty or out of range
// answers without touching the RAMs; a search or positional walk reads one node
// link per cycle from the link RAM, so the worst case grows with the list length.
// Reset is synchronous, active low, and takes effect at once: no clearing pass.
// A result waiting on i_out_ready does not block the next request.
module positional_linked_list_engine_unit #(
    parameter int unsigned CAPACITY = pll_pkg::CAPACITY_DEF,
    localparam int unsigned LW = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pll_pkg::t_op                        i_operation,
    input  logic [pll_pkg::POS_W-1:0]           i_position,
    input  logic signed [pll_pkg::VALUE_W-1:0]  i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pll_pkg::t_status                    o_status,
    output logic [LW-1:0]                       o_list_length
);

    import pll_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);

    t_mem_ctl           mem;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [LW-1:0]      link_wdata;
    logic [VALUE_W-1:0] value_wdata;
    logic [LW-1:0]      link_rdata;
    logic [VALUE_W-1:0] value_rdata;

    logic               res_valid;
    logic               res_ready;
    t_status            res_status;
    logic [LW-1:0]      res_length;

    // Output register state.
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status;
    logic [LW-1:0]      r_out_length;

    // Sequencer: checks, chain walks, allocation and relinking.
    pll_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res_status  (res_status),
        .o_res_length  (res_length),
        .o_mem         (mem),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_link_wdata  (link_wdata),
        .o_value_wdata (value_wdata),
        .i_link_rdata  (link_rdata),
        .i_value_rdata (value_rdata)
    );

    // Next link of each node; CAPACITY is the null code.
    pll_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_we      (mem.link_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (link_wdata),
        .i_re      (mem.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rdata)
    );

    // Stored value of each node, read alongside its link during a search.
    pll_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_we      (mem.value_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (value_wdata),
        .i_re      (mem.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (value_rdata)
    );

    // Take a new result whenever the output register is empty or draining.
    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the payload while a result waits.
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_status <= res_status;
            r_out_length <= res_length;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_list_length = r_out_length;

endmodule

### rtl/pll_checker.sv
`include "positional_linked_list_engine_unit_assert.svh"

module pll_checker #(
    parameter int unsigned CAPACITY = pll_pkg::CAPACITY_DEF,
    localparam int unsigned LW = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  pll_pkg::t_status                    o_status,
    input  logic [LW-1:0]                       o_list_length
);

    import pll_pkg::*;

    localparam logic [LW-1:0] CAP_LEN = LW'(CAPACITY);

    // One request in flight: ready drops right after an accept.
    `PLL_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // A stalled result holds.
    `PLL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_list_length))
    `PLL_ASSERT_IMPL(a_len_in_range, o_out_valid, o_list_length <= CAP_LEN)
    `PLL_ASSERT_IMPL(a_full_len, o_out_valid && o_status == ST_FULL, o_list_length == CAP_LEN)
    `PLL_ASSERT_IMPL(a_empty_len, o_out_valid && o_status == ST_EMPTY, o_list_length == '0)

endmodule

bind positional_linked_list_engine_unit pll_checker #(
    .CAPACITY (CAPACITY)
) u_pll_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_list_length (o_list_length)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pll_pkg::*;

    // Codes the engine must reject as out of range.
    localparam t_op OP_SPARE_6 = 3'd6;
    localparam t_op OP_SPARE_7 = 3'd7;

    localparam int unsigned CAPACITY     = CAPACITY_DEF;
    localparam int unsigned LEN_W        = $clog2(CAPACITY + 1);
    localparam int unsigned HOLD_CYCLES  = 300;
    // Drain margin after the last result, sized to cover the longest walk.
    localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 20;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    typedef logic [POS_W-1:0]          t_pos;
    typedef logic signed [VALUE_W-1:0] t_word;

    typedef struct {
        t_status          status;
        logic [LEN_W-1:0] length;
    } t_list_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_op              i_operation;
    t_pos             i_position;
    t_word            i_item_value;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_status          o_status;
    logic [LEN_W-1:0] o_list_length;

    // Mirror of the list contents, head first, updated as each request is taken.
    t_word        list_vals[$];
    t_list_answer pending_answers[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold = 1'b0;
    event        hold_go;

    int unsigned fail_count    = 0;
    int unsigned requests_sent = 0;
    int unsigned answers_seen  = 0;
    int unsigned peak_length   = 0;
    int unsigned status_hits[8];

    positional_linked_list_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_list_length (o_list_length)
    );

    always #10 i_clk = ~i_clk;

    // Apply one request to the mirror list and return the status it should give.
    // Full is checked before the position, empty before the position.
    function automatic t_status apply_list_op(input t_op op, input t_pos pos, input t_word val);
        int      n;
        int      idx;
        t_status st;
        n  = list_vals.size();
        st = ST_DONE;
        case (op)
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
                idx = (op == OP_APPEND) ? n + 1 : (op == OP_PREPEND) ? 1 : int'(pos);
                if (n >= CAPACITY)
                    st = ST_FULL;
                else if (idx < 1 || idx > n + 1)
                    st = ST_RANGE;
                else if (idx == n + 1)
                    list_vals.push_back(val);
                else
                    list_vals.insert(idx - 1, val);
            end
            OP_DEL_FIRST, OP_DEL_AT: begin
                idx = (op == OP_DEL_FIRST) ? 1 : int'(pos);
                if (n == 0)
                    st = ST_EMPTY;
                else if (idx < 1 || idx > n)
                    st = ST_RANGE;
                else
                    list_vals.delete(idx - 1);
            end
            OP_SEARCH: begin
                st = ST_NOT_FOUND;
                foreach (list_vals[k])
                    if (list_vals[k] == val)
                        st = ST_FOUND;
            end
            default: st = ST_RANGE;
        endcase
        return st;
    endfunction

    // Mix fresh words, extremes, small values (to get duplicates) and values already held.
    function automatic t_word pick_value();
        int unsigned r;
        t_word       v;
        r = $urandom_range(99);
        if (r < 15 && list_vals.size() != 0)
            v = list_vals[$urandom_range(list_vals.size() - 1)];
        else if (r < 25)
            case ($urandom_range(3))
                0: v = 32'sh8000_0000;
                1: v = 32'sh7FFF_FFFF;
                2: v = '0;
                default: v = '1;
            endcase
        else if (r < 35)
            v = t_word'($urandom_range(15));
        else
            v = t_word'($urandom);
        return v;
    endfunction

    // Mostly legal positions in 1..span, with the edges, zero and any 8-bit value.
    function automatic t_pos pick_position(input int unsigned span);
        int unsigned r;
        int unsigned top;
        t_pos        p;
        r   = $urandom_range(99);
        top = (span == 0) ? 1 : span;
        if (r < 70)
            p = t_pos'($urandom_range(top, 1));
        else if (r < 80)
            p = $urandom_range(1) ? t_pos'(1) : t_pos'(top);
        else if (r < 90)
            p = '0;
        else
            p = t_pos'($urandom_range(255));
        return p;
    endfunction

    // Offer one request, hold it until taken, then record what it should answer.
    // Call only at a rising edge; leaves the caller at the edge of acceptance.
    task automatic send_request(input t_op op, input t_pos pos, input t_word val);
        t_list_answer want;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_position   <= pos;
        i_item_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want.status = apply_list_op(op, pos, val);
        want.length = LEN_W'(list_vals.size());
        pending_answers.push_back(want);
        requests_sent++;
        if (list_vals.size() > peak_length)
            peak_length = list_vals.size();
    endtask

    // Pick the next random request; grow favors inserts, otherwise deletes.
    task automatic send_random_request(input bit grow);
        int unsigned r;
        int unsigned n;
        t_op         op;
        t_pos        pos;
        n = list_vals.size();
        r = $urandom_range(99);
        if (r < 3)
            op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        else if (grow)
            op = (r < 23) ? OP_APPEND : (r < 38) ? OP_PREPEND : (r < 63) ? OP_INSERT :
                 (r < 70) ? OP_DEL_FIRST : (r < 80) ? OP_DEL_AT : OP_SEARCH;
        else
            op = (r < 10) ? OP_APPEND : (r < 15) ? OP_PREPEND : (r < 25) ? OP_INSERT :
                 (r < 45) ? OP_DEL_FIRST : (r < 73) ? OP_DEL_AT : OP_SEARCH;
        case (op)
            OP_INSERT: pos = pick_position(n + 1);
            OP_DEL_AT: pos = pick_position(n);
            default:   pos = t_pos'($urandom_range(255));
        endcase
        send_request(op, pos, pick_value());
    endtask

    // Empty-list answers, both ends of position and value, every code, tail removal.
    task automatic test_directed_edges();
        send_request(OP_SEARCH,    8'd0,   32'sd0);
        send_request(OP_DEL_FIRST, 8'd0,   32'sd0);
        send_request(OP_DEL_AT,    8'd0,   32'sd0);
        send_request(OP_DEL_AT,    8'd255, 32'sd0);
        send_request(OP_INSERT,    8'd0,   32'sd5);
        send_request(OP_INSERT,    8'd2,   32'sd5);
        send_request(OP_INSERT,    8'd1,   32'sh7FFF_FFFF);
        send_request(OP_SPARE_6,   8'd1,   32'sd1);
        send_request(OP_SPARE_7,   8'd255, -32'sd1);
        send_request(OP_APPEND,    8'd255, 32'sh8000_0000);
        send_request(OP_PREPEND,   8'd0,   -32'sd1);
        send_request(OP_INSERT,    8'd4,   32'sd0);
        send_request(OP_INSERT,    8'd6,   32'sd9);
        send_request(OP_INSERT,    8'd3,   32'sh5555_5555);
        send_request(OP_SEARCH,    8'd0,   32'sh8000_0000);
        send_request(OP_SEARCH,    8'd0,   32'shAAAA_AAAA);
        send_request(OP_SEARCH,    8'd0,   32'sd0);
        send_request(OP_DEL_AT,    8'd0,   32'sd0);
        send_request(OP_DEL_AT,    8'd6,   32'sd0);
        send_request(OP_DEL_AT,    8'd5,   32'sd0);
        send_request(OP_DEL_AT,    8'd2,   32'sd0);
        send_request(OP_DEL_FIRST, 8'd0,   32'sd0);
        send_request(OP_SEARCH,    8'd0,   32'sh7FFF_FFFF);
        send_request(OP_DEL_AT,    8'd2,   32'sd0);
        send_request(OP_DEL_FIRST, 8'd0,   32'sd0);
    endtask

    // Fill the store, try every insert form against it, then empty it by first and positional deletes.
    task automatic test_fill_and_drain();
        t_op op;
        while (list_vals.size() < CAPACITY) begin
            case ($urandom_range(2))
                0: op = OP_APPEND;
                1: op = OP_PREPEND;
                default: op = OP_INSERT;
            endcase
            send_request(op, t_pos'($urandom_range(list_vals.size() + 1, 1)), pick_value());
        end
        send_request(OP_APPEND,  8'd0,   32'sd1);
        send_request(OP_PREPEND, 8'd0,   32'sd1);
        send_request(OP_INSERT,  8'd0,   32'sd1);
        send_request(OP_INSERT,  8'd65,  32'sd1);
        send_request(OP_SEARCH,  8'd0,   list_vals[CAPACITY - 1]);
        send_request(OP_DEL_AT,  8'd255, 32'sd0);
        send_request(OP_DEL_AT,  8'd65,  32'sd0);
        send_request(OP_DEL_AT,  8'd64,  32'sd0);
        while (list_vals.size() != 0) begin
            if ($urandom_range(3) == 0)
                send_request(OP_DEL_FIRST, t_pos'($urandom_range(255)), pick_value());
            else
                send_request(OP_DEL_AT, t_pos'($urandom_range(list_vals.size(), 1)),
                             pick_value());
        end
    endtask

    // Random traffic that swings between growing toward full and draining toward empty.
    task automatic test_random_mix(input int unsigned count);
        bit grow;
        grow = 1'b1;
        repeat (count) begin
            if (list_vals.size() == 0)
                grow = 1'b1;
            else if (list_vals.size() == CAPACITY && $urandom_range(3) == 0)
                grow = 1'b0;
            else if ($urandom_range(49) == 0)
                grow = !grow;
            send_random_request(grow);
        end
    endtask

    // Hold off the result side long enough that the engine backs up its request side.
    task automatic test_output_hold();
        -> hold_go;
        repeat (40)
            send_random_request($urandom_range(1));
    endtask

    // Result side: random stalls, plus the long hold when asked.
    always @(posedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Count out the long hold in cycles here, away from the request side.
    always begin
        @(hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Compare every taken result against the oldest answer still owed.
    always @(posedge i_clk) begin : answer_check
        t_list_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            answers_seen++;
            status_hits[o_status]++;
            if (pending_answers.size() == 0) begin
                $error("result with nothing owed: status %0d, list_length %0d",
                       o_status, o_list_length);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_list_length !== want.length) begin
                    $error("list_length mismatch: expected %0d, actual %0d",
                           want.length, o_list_length);
                    fail_count++;
                end
            end
        end
    end

    // Give up on a hang.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_operation  <= OP_SEARCH;
        i_position   <= '0;
        i_item_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles often, receiver more often.
        tx_idle_pct = 35;
        rx_idle_pct = 50;
        test_directed_edges();
        test_fill_and_drain();
        test_random_mix(400);

        // Swap the stall pressure.
        tx_idle_pct = 50;
        rx_idle_pct = 35;
        test_random_mix(450);

        // Full rate both ways, then the long result-side hold.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_mix(400);
        test_output_hold();

        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d results checked), list peaked at %0d of %0d entries.",
                 requests_sent, answers_seen, peak_length, CAPACITY);
        $display("Statuses: done %0d, found %0d, not found %0d, empty %0d, range %0d, full %0d.",
                 status_hits[ST_DONE], status_hits[ST_FOUND], status_hits[ST_NOT_FOUND],
                 status_hits[ST_EMPTY], status_hits[ST_RANGE], status_hits[ST_FULL]);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
